FILE: rtl/irt_pkg.sv
package irt_pkg;

   // Default geometry of the table.
   localparam int TABLE_DEPTH_DEF    = 64;
   localparam int NEURON_ID_BITS_DEF = 12;

   // Fixed field widths.
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int NKIND_W = 3;
   localparam int SPLIT_W = 16;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_SEED   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

   // Result status codes.
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOMATCH = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

   // Neuron kind returned by a lookup that finds nothing.
   localparam logic [NKIND_W-1:0] KIND_HIDDEN = 3'd1;

   // Controls broadcast from the sequencer to every cell.
   typedef struct packed {
      logic write;      // store the broadcast entry in the cell at the fill position
      logic load;       // capture match flag and payload into the scan stage
      logic shift;      // move the scan stage one cell toward the head
      logic lookup;     // match on neuron ID instead of (from, to, kind)
   } cell_ctrl_type;

endpackage

FILE: rtl/irt_cell.sv
module irt_cell #(
   parameter int CELL_INDEX = 0,
   parameter int IDW        = 13,
   parameter int CNTW       = 7
) (
   input  logic                   clock,
   input  irt_pkg::cell_ctrl_type ctrl,
   input  logic [CNTW-1:0]        count,
   // Entry being appended.
   input  logic [IDW-1:0]         wr_from,
   input  logic [IDW-1:0]         wr_to,
   input  logic [IDW-1:0]         wr_nid,
   input  logic [2:0]             wr_nkind,
   input  logic                   wr_ikind,
   input  logic [31:0]            wr_split,
   // Query fields.
   input  logic [IDW-1:0]         q_from,
   input  logic [IDW-1:0]         q_to,
   input  logic                   q_ikind,
   input  logic [IDW-1:0]         q_nid,
   // Scan chain: from the next cell in, toward the head out.
   input  logic                   scan_hit_next,
   input  logic [34:0]            scan_data_next,
   output logic                   scan_hit,
   output logic [34:0]            scan_data
);
   import irt_pkg::*;

   logic [IDW-1:0] from_ff, to_ff, nid_ff;
   logic [2:0]     nkind_ff;
   logic           ikind_ff;
   logic [31:0]    split_ff;
   logic           hit_ff, hit_in;
   logic [34:0]    data_ff, data_in;
   logic           written;
   logic           match;

   // The cell holds a live entry once the fill count has passed it.
   assign written = count > CNTW'(CELL_INDEX);

   always_comb begin
      if (ctrl.lookup) begin
         match = (nid_ff == q_nid);
      end else begin
         match = (from_ff == q_from) && (to_ff == q_to) && (ikind_ff == q_ikind);
      end
   end

   // Entry storage, written once at its position.
   always_ff @(posedge clock) begin
      if (ctrl.write && count == CNTW'(CELL_INDEX)) begin
         from_ff  <= wr_from;
         to_ff    <= wr_to;
         nid_ff   <= wr_nid;
         nkind_ff <= wr_nkind;
         ikind_ff <= wr_ikind;
         split_ff <= wr_split;
      end
   end

   // Scan stage: load the local match, then pass results toward the head.
   always_comb begin
      hit_in  = hit_ff;
      data_in = data_ff;
      if (ctrl.load) begin
         hit_in  = written && match;
         data_in = {split_ff, nkind_ff};
      end else if (ctrl.shift) begin
         hit_in  = scan_hit_next;
         data_in = scan_data_next;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff  <= hit_in;
      data_ff <= data_in;
   end

   assign scan_hit  = hit_ff;
   assign scan_data = data_ff;

endmodule

FILE: rtl/innovation_registry_table.sv
// Innovation registry table. Seed and create commands append one entry, or
// report full, and answer in the cycle after acceptance. Check and lookup
// commands run a scan through the row of entry cells: the load step captures
// every cell's match, then one cell per cycle moves to the head of the row
// while the result register can take a result; a lookup stops at its first
// hit. A new transaction is taken only when the block is idle and the result
// register is empty. Check returns every matching innovation in table order
// with tlast on the final one, or a single no-match result.
module innovation_registry_table #(
   parameter int TABLE_DEPTH    = irt_pkg::TABLE_DEPTH_DEF,
   parameter int NEURON_ID_BITS = irt_pkg::NEURON_ID_BITS_DEF,
   localparam int IDW    = NEURON_ID_BITS + 1,
   localparam int IW     = $clog2(TABLE_DEPTH),
   localparam int REQ_W  = 2 + 2 * IDW + 1 + 3 + 32 + NEURON_ID_BITS,
   localparam int REQ_BW = ((REQ_W + 7) / 8) * 8,
   localparam int RSP_W  = 2 + IW + IDW + 3 + 32,
   localparam int RSP_BW = ((RSP_W + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // command, neuron_from, neuron_to, innov_kind, neuron_kind, split_x,
   // split_y, neuron_number, zero pad
   input  logic [REQ_BW-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // status, innovation_number, neuron_result, neuron_kind_out,
   // split_x_out, split_y_out, zero pad
   output logic [RSP_BW-1:0] rsp_tdata,
   output logic              rsp_tlast
);
   import irt_pkg::*;

   localparam int CNTW = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDW-1:0] ID_MASK  = {IDW{1'b1}};
   localparam logic [IDW-1:0] ID_LIMIT = IDW'(1) << NEURON_ID_BITS;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_LOAD  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [IDW-1:0]  next_id_ff, next_id_in;
   logic [IW-1:0]   scan_ff, scan_in;
   logic            pend_ff, pend_in;
   logic [IW-1:0]   pend_idx_ff, pend_idx_in;

   // Query registers.
   logic [CMD_W-1:0] q_cmd_ff;
   logic [IDW-1:0]   q_from_ff, q_to_ff, q_nid_ff;
   logic             q_ikind_ff;

   // Result register.
   logic              out_valid_ff, out_valid_in;
   logic [RSP_W-1:0]  out_data_ff, out_data_in;
   logic              out_last_ff, out_last_in;

   // Unpacked request fields.
   logic [CMD_W-1:0]          r_cmd;
   logic [IDW-1:0]            r_from, r_to;
   logic                      r_ikind;
   logic [2:0]                r_nkind;
   logic [31:0]               r_split;
   logic [NEURON_ID_BITS-1:0] r_nn;
   logic [IDW-1:0]            r_nn_ext, r_nn_inc;

   assign r_cmd    = req_tdata[1:0];
   assign r_from   = req_tdata[2 +: IDW];
   assign r_to     = req_tdata[2 + IDW +: IDW];
   assign r_ikind  = req_tdata[2 + 2 * IDW];
   assign r_nkind  = req_tdata[3 + 2 * IDW +: 3];
   assign r_split  = req_tdata[6 + 2 * IDW +: 32];
   assign r_nn     = req_tdata[38 + 2 * IDW +: NEURON_ID_BITS];
   assign r_nn_ext = {1'b0, r_nn};
   assign r_nn_inc = r_nn_ext + IDW'(1);

   logic accept, out_free, full;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign full       = count_ff == CNTW'(TABLE_DEPTH);

   // Cell row.
   cell_ctrl_type   ctrl;
   logic [IDW-1:0]  wr_from, wr_to, wr_nid;
   logic [2:0]      wr_nkind;
   logic            wr_ikind;
   logic [31:0]     wr_split;
   logic            hit_w  [TABLE_DEPTH+1];
   logic [34:0]     data_w [TABLE_DEPTH+1];

   assign hit_w[TABLE_DEPTH]  = 1'b0;
   assign data_w[TABLE_DEPTH] = '0;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      irt_cell #(
         .CELL_INDEX(g),
         .IDW       (IDW),
         .CNTW      (CNTW)
      ) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .count         (count_ff),
         .wr_from       (wr_from),
         .wr_to         (wr_to),
         .wr_nid        (wr_nid),
         .wr_nkind      (wr_nkind),
         .wr_ikind      (wr_ikind),
         .wr_split      (wr_split),
         .q_from        (q_from_ff),
         .q_to          (q_to_ff),
         .q_ikind       (q_ikind_ff),
         .q_nid         (q_nid_ff),
         .scan_hit_next (hit_w[g+1]),
         .scan_data_next(data_w[g+1]),
         .scan_hit      (hit_w[g]),
         .scan_data     (data_w[g])
      );
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      next_id_in   = next_id_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      ctrl         = '0;
      ctrl.lookup  = q_cmd_ff == CMD_LOOKUP;
      wr_from      = r_from;
      wr_to        = r_to;
      wr_nid       = ID_MASK;
      wr_nkind     = r_nkind;
      wr_ikind     = r_ikind;
      wr_split     = r_split;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               out_last_in = 1'b1;
               case (r_cmd)
                  CMD_SEED: begin
                     out_valid_in = 1'b1;
                     if (full) begin
                        out_data_in = {35'd0, IDW'(0), IW'(0), STAT_FULL};
                     end else begin
                        ctrl.write = 1'b1;
                        wr_from    = ID_MASK;
                        wr_to      = ID_MASK;
                        wr_nid     = r_nn_ext;
                        wr_ikind   = 1'b1;
                        count_in   = count_ff + CNTW'(1);
                        if (r_nn_inc > next_id_ff) begin
                           next_id_in = r_nn_inc;
                        end
                        out_data_in = {35'd0, r_nn_ext, count_ff[IW-1:0], STAT_OK};
                     end
                  end
                  CMD_CREATE: begin
                     out_valid_in = 1'b1;
                     if (full || (r_ikind && next_id_ff >= ID_LIMIT)) begin
                        out_data_in = {35'd0, IDW'(0), IW'(0), STAT_FULL};
                     end else begin
                        ctrl.write = 1'b1;
                        count_in   = count_ff + CNTW'(1);
                        if (r_ikind) begin
                           wr_nid      = next_id_ff;
                           next_id_in  = next_id_ff + IDW'(1);
                           out_data_in = {35'd0, next_id_ff, count_ff[IW-1:0], STAT_OK};
                        end else begin
                           out_data_in = {35'd0, next_id_ff - IDW'(1),
                                          count_ff[IW-1:0], STAT_OK};
                        end
                     end
                  end
                  default: begin
                     state_in = ST_LOAD;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            ctrl.load = 1'b1;
            scan_in   = '0;
            pend_in   = 1'b0;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (out_free) begin
               ctrl.shift = 1'b1;
               scan_in    = scan_ff + IW'(1);
               if (scan_ff == IW'(TABLE_DEPTH - 1)) begin
                  state_in = ST_FLUSH;
               end
               if (hit_w[0]) begin
                  if (ctrl.lookup) begin
                     out_valid_in = 1'b1;
                     out_last_in  = 1'b1;
                     out_data_in  = {data_w[0][34:3], data_w[0][2:0], q_nid_ff,
                                     scan_ff, STAT_OK};
                     state_in     = ST_IDLE;
                  end else begin
                     // Hold each hit until the next one shows it is not the last.
                     if (pend_ff) begin
                        out_valid_in = 1'b1;
                        out_last_in  = 1'b0;
                        out_data_in  = {35'd0, IDW'(0), pend_idx_ff, STAT_OK};
                     end
                     pend_in     = 1'b1;
                     pend_idx_in = scan_ff;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
               if (ctrl.lookup) begin
                  out_data_in = {32'd0, KIND_HIDDEN, IDW'(0), IW'(0), STAT_NOMATCH};
               end else if (pend_ff) begin
                  out_data_in = {35'd0, IDW'(0), pend_idx_ff, STAT_OK};
               end else begin
                  out_data_in = {35'd0, IDW'(0), IW'(0), STAT_NOMATCH};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         next_id_ff   <= IDW'(1);
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // Payload and query registers.
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      if (accept) begin
         q_cmd_ff   <= r_cmd;
         q_from_ff  <= r_from;
         q_to_ff    <= r_to;
         q_ikind_ff <= r_ikind;
         q_nid_ff   <= r_nn_ext;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(RSP_BW - RSP_W){1'b0}}, out_data_ff};

endmodule

FILE: bench/tb_innovation_registry_table.sv
`timescale 1ns / 100ps

module tb_innovation_registry_table;
   import irt_pkg::*;

   localparam int DEPTH  = TABLE_DEPTH_DEF;
   localparam int NIDB   = NEURON_ID_BITS_DEF;
   localparam int IDW    = NIDB + 1;
   localparam int IW     = $clog2(DEPTH);
   localparam int REQ_W  = 2 + 2 * IDW + 1 + 3 + 32 + NIDB;
   localparam int REQ_BW = ((REQ_W + 7) / 8) * 8;
   localparam int RSP_W  = 2 + IW + IDW + 3 + 32;
   localparam int RSP_BW = ((RSP_W + 7) / 8) * 8;
   localparam logic [IDW-1:0] NO_NEURON = '1;
   localparam int ID_LIMIT = 1 << NIDB;

   typedef struct packed {
      logic [NIDB-1:0]    number;
      logic [15:0]        sy;
      logic [15:0]        sx;
      logic [NKIND_W-1:0] nkind;
      logic               ikind;
      logic [IDW-1:0]     to;
      logic [IDW-1:0]     from;
      logic [CMD_W-1:0]   cmd;
   } request_type;

   typedef struct packed {
      logic               last;
      logic [15:0]        sy;
      logic [15:0]        sx;
      logic [NKIND_W-1:0] nkind;
      logic [IDW-1:0]     nres;
      logic [IW-1:0]      innov;
      logic [STAT_W-1:0]  status;
   } answer_type;

   typedef struct {
      logic [IDW-1:0]     from;
      logic [IDW-1:0]     to;
      logic [IDW-1:0]     nid;
      logic [NKIND_W-1:0] nkind;
      logic               ikind;
      logic [15:0]        sx;
      logic [15:0]        sy;
   } innovation_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_BW-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_BW-1:0] rsp_tdata;
   logic rsp_tlast;

   innovation_registry_table DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   request_type    pending_requests[$];
   answer_type     expected_answers[$];
   innovation_type registry[$];
   logic [IDW:0]   next_id;
   int             error_count;
   int             idle_pct;
   int             stall_pct;
   bit             sender_active;

   // Predict the answers of one accepted transaction and update the registry copy.
   task automatic predict_registry(input request_type rq);
      answer_type     a;
      innovation_type e;
      int             found;
      begin
         a = '0;
         a.last = 1'b1;
         found = 0;
         case (rq.cmd)
            CMD_SEED: begin
               if (registry.size() >= DEPTH) begin
                  a.status = STAT_FULL;
               end else begin
                  e = '{NO_NEURON, NO_NEURON, {1'b0, rq.number}, rq.nkind, 1'b1,
                        rq.sx, rq.sy};
                  a.innov = IW'(registry.size());
                  registry.push_back(e);
                  if ({2'b00, rq.number} + 1'b1 > next_id) begin
                     next_id = {2'b00, rq.number} + 1'b1;
                  end
                  a.nres = {1'b0, rq.number};
               end
               expected_answers.push_back(a);
            end
            CMD_CREATE: begin
               if (registry.size() >= DEPTH || (rq.ikind && next_id >= ID_LIMIT)) begin
                  a.status = STAT_FULL;
               end else begin
                  e = '{rq.from, rq.to, NO_NEURON, rq.nkind, rq.ikind, rq.sx, rq.sy};
                  if (rq.ikind) begin
                     e.nid = next_id[IDW-1:0];
                     next_id = next_id + 1'b1;
                  end
                  a.innov = IW'(registry.size());
                  registry.push_back(e);
                  a.nres = next_id[IDW-1:0] - 1'b1;
               end
               expected_answers.push_back(a);
            end
            CMD_CHECK: begin
               for (int i = 0; i < registry.size(); i++) begin
                  if (registry[i].from == rq.from && registry[i].to == rq.to &&
                      registry[i].ikind == rq.ikind) begin
                     a = '0;
                     a.innov = IW'(i);
                     expected_answers.push_back(a);
                     found++;
                  end
               end
               if (found == 0) begin
                  a = '0;
                  a.status = STAT_NOMATCH;
                  a.last = 1'b1;
                  expected_answers.push_back(a);
               end else begin
                  expected_answers[$].last = 1'b1;
               end
            end
            default: begin
               for (int i = 0; i < registry.size() && found == 0; i++) begin
                  if (registry[i].nid == {1'b0, rq.number}) begin
                     a.innov = IW'(i);
                     a.nres = registry[i].nid;
                     a.nkind = registry[i].nkind;
                     a.sx = registry[i].sx;
                     a.sy = registry[i].sy;
                     found = 1;
                  end
               end
               if (found == 0) begin
                  a.status = STAT_NOMATCH;
                  a.nkind = KIND_HIDDEN;
               end
               expected_answers.push_back(a);
            end
         endcase
      end
   endtask

   function automatic request_type random_request(input logic [CMD_W-1:0] cmd);
      request_type rq;
      begin
         rq.cmd = cmd;
         // Mostly reuse a small set of ends so checks find several matches.
         rq.from = ($urandom_range(0, 3) == 0) ? IDW'($urandom_range(0, ID_LIMIT - 1)) :
                   IDW'($urandom_range(0, 4) - 1);
         rq.to = ($urandom_range(0, 3) == 0) ? IDW'($urandom_range(0, ID_LIMIT - 1)) :
                 IDW'($urandom_range(0, 4) - 1);
         rq.ikind = 1'($urandom_range(0, 1));
         rq.nkind = NKIND_W'($urandom_range(0, 7));
         rq.sx = 16'($urandom);
         rq.sy = 16'($urandom);
         rq.number = ($urandom_range(0, 2) == 0) ? NIDB'($urandom_range(0, ID_LIMIT - 1)) :
                     NIDB'($urandom_range(0, 40));
         return rq;
      end
   endfunction

   function automatic request_type directed_request(input logic [CMD_W-1:0] cmd,
      input logic [IDW-1:0] from, input logic [IDW-1:0] to, input logic ik,
      input logic [NKIND_W-1:0] nk, input logic [15:0] sx, input logic [15:0] sy,
      input logic [NIDB-1:0] number);
      request_type rq;
      begin
         rq = '{number, sy, sx, nk, ik, to, from, cmd};
         return rq;
      end
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver: presents queued transactions and predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_registry(request_type'(req_tdata[REQ_W-1:0]));
            void'(pending_requests.pop_front());
         end
         if ((!req_tvalid || req_tready) && sender_active) begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= REQ_BW'(pending_requests[0]);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every accepted result against the oldest expectation.
   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = answer_type'({rsp_tlast, rsp_tdata[RSP_W-1:0]});
            if (expected_answers.size() == 0) begin
               $error("unexpected result transaction %h", got);
               error_count++;
            end else begin
               want = expected_answers.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, got.status);
                  error_count++;
               end
               if (got.innov !== want.innov) begin
                  $error("innovation_number: expected %0d actual %0d", want.innov, got.innov);
                  error_count++;
               end
               if (got.nres !== want.nres) begin
                  $error("neuron_result: expected %0d actual %0d", want.nres, got.nres);
                  error_count++;
               end
               if (got.nkind !== want.nkind) begin
                  $error("neuron_kind_out: expected %0d actual %0d", want.nkind, got.nkind);
                  error_count++;
               end
               if (got.sx !== want.sx) begin
                  $error("split_x_out: expected %h actual %h", want.sx, got.sx);
                  error_count++;
               end
               if (got.sy !== want.sy) begin
                  $error("split_y_out: expected %h actual %h", want.sy, got.sy);
                  error_count++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d actual %0d", want.last, got.last);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Stimulus: a directed sequence, then random runs in several idling and stalling phases.
   initial begin
      logic [CMD_W-1:0] cmd;
      reset = 1'b1;
      error_count = 0;
      idle_pct = 0;
      stall_pct = 0;
      sender_active = 1'b0;
      registry.delete();
      next_id = {{IDW{1'b0}}, 1'b1};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty-table lookup and check, seeds at both ends, both create kinds, then checks and lookups.
      pending_requests.push_back(directed_request(CMD_LOOKUP, '0, '0, 1'b0, '0, '0, '0,
                                                  '0));
      pending_requests.push_back(directed_request(CMD_CHECK, NO_NEURON, NO_NEURON, 1'b1,
                                                  '0, '0, '0, '0));
      pending_requests.push_back(directed_request(CMD_SEED, '0, '0, 1'b0, '0, 16'h0000,
                                                  16'hFFFF, '0));
      pending_requests.push_back(directed_request(CMD_SEED, '0, '0, 1'b0, 3'd7, 16'hFFFF,
                                                  16'h0000, 12'd5));
      pending_requests.push_back(directed_request(CMD_CREATE, 13'h0FFF, '0, 1'b0, 3'd4,
                                                  16'hAAAA, 16'h5555, '0));
      pending_requests.push_back(directed_request(CMD_CREATE, '0, 13'h0FFF, 1'b1, 3'd2,
                                                  16'h5555, 16'hAAAA, '0));
      pending_requests.push_back(directed_request(CMD_CREATE, NO_NEURON, NO_NEURON, 1'b1,
                                                  3'd3, '0, '0, '0));
      pending_requests.push_back(directed_request(CMD_CHECK, NO_NEURON, NO_NEURON, 1'b1,
                                                  '0, '0, '0, '0));
      pending_requests.push_back(directed_request(CMD_CHECK, 13'h0FFF, '0, 1'b0, '0, '0,
                                                  '0, '0));
      pending_requests.push_back(directed_request(CMD_LOOKUP, '0, '0, 1'b0, '0, '0, '0,
                                                  12'd5));
      pending_requests.push_back(directed_request(CMD_LOOKUP, '0, '0, 1'b0, '0, '0, '0,
                                                  12'd7));
      pending_requests.push_back(directed_request(CMD_LOOKUP, '0, '0, 1'b0, '0, '0, '0,
                                                  '0));
      // Seeding the top ID exhausts neuron IDs; a neuron create then reports full.
      pending_requests.push_back(directed_request(CMD_SEED, '0, '0, 1'b0, 3'd1, 16'h1234,
                                                  16'h4321, 12'hFFF));
      pending_requests.push_back(directed_request(CMD_CREATE, 13'd1, 13'd2, 1'b1, 3'd1,
                                                  '0, '0, '0));
      pending_requests.push_back(directed_request(CMD_CREATE, 13'd1, 13'd2, 1'b0, 3'd1,
                                                  '0, '0, '0));
      pending_requests.push_back(directed_request(CMD_LOOKUP, '0, '0, 1'b0, '0, '0, '0,
                                                  12'hFFF));
      sender_active = 1'b1;

      // Random phases; the table fills along the way and then overflows.
      for (int phase = 0; phase < 4; phase++) begin
         wait (pending_requests.size() == 0);
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 10; stall_pct = 10; end
         endcase
         for (int k = 0; k < 50; k++) begin
            cmd = ($urandom_range(0, 9) < 4) ? CMD_CREATE : CMD_W'($urandom_range(0, 3));
            pending_requests.push_back(random_request(cmd));
         end
      end

      wait (pending_requests.size() == 0 && !req_tvalid);
      wait (expected_answers.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: files.f
rtl/irt_pkg.sv
rtl/irt_cell.sv
rtl/innovation_registry_table.sv
bench/tb_innovation_registry_table.sv
